/* design/mhp_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mhp_pkg
// Types and codes shared by the heap controller, datapath and top level.
// ----------------------------------------------------------------------------
package mhp_pkg;

    localparam int unsigned VALUE_W  = 32;
    localparam int unsigned STATUS_W = 2;

    localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd2;

    localparam logic KIND_LOAD    = 1'b0;
    localparam logic KIND_EXTRACT = 1'b1;

    localparam logic [VALUE_W-1:0] VALUE_EMPTY = '1;
    localparam logic [VALUE_W-1:0] VALUE_LOAD  = '0;

    typedef enum logic [3:0] {
        S_IDLE,
        S_LOAD,
        S_EXT_READ,
        S_EXT_TAKE,
        S_BLD_INIT,
        S_BLD_NEXT,
        S_BLD_TAKE,
        S_SIFT_READ,
        S_SIFT_WRITE,
        S_FINISH
    } t_state;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_CAPTURE,
        OP_APPEND,
        OP_EXT_EMPTY,
        OP_EXT_READ,
        OP_EXT_TAKE,
        OP_BLD_INIT,
        OP_BLD_DEC,
        OP_CUR_TAKE,
        OP_SIFT_READ,
        OP_SIFT_WRITE,
        OP_OUT_LOAD
    } t_dp_op;

    typedef struct packed {
        t_dp_op op;
    } t_dp_cmd;

    typedef struct packed {
        logic kind;
        logic last;
        logic empty;
        logic node_zero;
        logic sift_more;
        logic out_busy;
    } t_dp_stat;

endpackage
`default_nettype wire

/* design/mhp_ctrl.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mhp_ctrl
// Sequencer for load, heap build, extract and sift-down steps.
// ----------------------------------------------------------------------------
module mhp_ctrl
    import mhp_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_req_valid,
    output logic          o_req_ready,
    input  wire t_dp_stat i_stat,
    output t_dp_cmd       o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state     = r_state;
        o_cmd.op    = OP_NONE;
        o_req_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_req_ready = i_rst_n;
                if (i_req_valid && i_rst_n) begin
                    o_cmd.op = OP_CAPTURE;
                    n_state  = S_LOAD;
                end
            end
            S_LOAD: begin
                if (i_stat.kind == KIND_EXTRACT) begin
                    n_state = S_EXT_READ;
                end else begin
                    o_cmd.op = OP_APPEND;
                    n_state  = i_stat.last ? S_BLD_INIT : S_FINISH;
                end
            end
            S_EXT_READ: begin
                if (i_stat.empty) begin
                    o_cmd.op = OP_EXT_EMPTY;
                    n_state  = S_FINISH;
                end else begin
                    o_cmd.op = OP_EXT_READ;
                    n_state  = S_EXT_TAKE;
                end
            end
            S_EXT_TAKE: begin
                o_cmd.op = OP_EXT_TAKE;
                n_state  = S_SIFT_READ;
            end
            S_BLD_INIT: begin
                o_cmd.op = OP_BLD_INIT;
                n_state  = S_BLD_NEXT;
            end
            S_BLD_NEXT: begin
                if (i_stat.node_zero) begin
                    n_state = S_FINISH;
                end else begin
                    o_cmd.op = OP_BLD_DEC;
                    n_state  = S_BLD_TAKE;
                end
            end
            S_BLD_TAKE: begin
                o_cmd.op = OP_CUR_TAKE;
                n_state  = S_SIFT_READ;
            end
            S_SIFT_READ: begin
                o_cmd.op = OP_SIFT_READ;
                n_state  = S_SIFT_WRITE;
            end
            S_SIFT_WRITE: begin
                o_cmd.op = OP_SIFT_WRITE;
                if (i_stat.sift_more) begin
                    n_state = S_SIFT_READ;
                end else if (i_stat.kind == KIND_EXTRACT) begin
                    n_state = S_FINISH;
                end else begin
                    n_state = S_BLD_NEXT;
                end
            end
            S_FINISH: begin
                if (!i_stat.out_busy) begin
                    o_cmd.op = OP_OUT_LOAD;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule
`default_nettype wire

/* design/mhp_dpath.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mhp_dpath
// Heap store, element count, sift position and result register.
// ----------------------------------------------------------------------------
module mhp_dpath
    import mhp_pkg::*;
#(
    parameter int unsigned HEAP_DEPTH = 1024
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire t_dp_cmd             i_cmd,
    input  wire logic                i_req_kind,
    input  wire logic [VALUE_W-1:0]  i_req_value,
    input  wire logic                i_req_last,
    input  wire logic                i_rsp_ready,
    output logic                     o_rsp_valid,
    output logic [VALUE_W-1:0]       o_rsp_value,
    output logic [STATUS_W-1:0]      o_rsp_status,
    output t_dp_stat                 o_stat
);

    localparam int unsigned ADDR_W = (HEAP_DEPTH > 1) ? $clog2(HEAP_DEPTH) : 1;
    localparam int unsigned CNT_W  = $clog2(HEAP_DEPTH + 1);
    localparam int unsigned CH_W   = ADDR_W + 2;
    localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(HEAP_DEPTH);

    logic [VALUE_W-1:0] r_mem [HEAP_DEPTH];

    logic                r_kind;
    logic [VALUE_W-1:0]  r_value;
    logic                r_last;
    logic [CNT_W-1:0]    r_count;
    logic [CNT_W-1:0]    r_node;
    logic [ADDR_W-1:0]   r_pos;
    logic [VALUE_W-1:0]  r_cur;
    logic [VALUE_W-1:0]  r_rd0;
    logic [VALUE_W-1:0]  r_rd1;
    logic [VALUE_W-1:0]  r_res_value;
    logic [STATUS_W-1:0] r_res_status;
    logic                r_out_valid;
    logic [VALUE_W-1:0]  r_out_value;
    logic [STATUS_W-1:0] r_out_status;

    logic [ADDR_W-1:0]  rd_addr0;
    logic [ADDR_W-1:0]  rd_addr1;
    logic               wr_en;
    logic [ADDR_W-1:0]  wr_addr;
    logic [VALUE_W-1:0] wr_data;

    logic [CH_W-1:0]    left_idx;
    logic [CH_W-1:0]    right_idx;
    logic [CH_W-1:0]    count_ext;
    logic               has_left;
    logic               has_right;
    logic [VALUE_W-1:0] best_val;
    logic [CH_W-1:0]    best_idx;
    logic               descend;
    logic               full;
    logic [CNT_W-1:0]   node_dec;

    assign left_idx  = {1'b0, r_pos, 1'b1};
    assign right_idx = left_idx + CH_W'(1);
    assign count_ext = CH_W'(r_count);
    assign has_left  = left_idx < count_ext;
    assign has_right = right_idx < count_ext;
    assign full      = r_count == DEPTH_CNT;
    assign node_dec  = r_node - CNT_W'(1);

    // pick the larger child; left wins a tie
    always_comb begin
        best_val = r_cur;
        best_idx = {2'b00, r_pos};
        if (has_left && ($signed(r_rd0) > $signed(best_val))) begin
            best_val = r_rd0;
            best_idx = left_idx;
        end
        if (has_right && ($signed(r_rd1) > $signed(best_val))) begin
            best_val = r_rd1;
            best_idx = right_idx;
        end
    end

    assign descend = best_idx != {2'b00, r_pos};

    always_comb begin
        rd_addr0 = '0;
        rd_addr1 = '0;
        wr_en    = 1'b0;
        wr_addr  = r_pos;
        wr_data  = r_cur;
        unique case (i_cmd.op)
            OP_EXT_READ: begin
                rd_addr1 = ADDR_W'(r_count - CNT_W'(1));
            end
            OP_BLD_DEC: begin
                rd_addr0 = ADDR_W'(node_dec);
            end
            OP_SIFT_READ: begin
                rd_addr0 = left_idx[ADDR_W-1:0];
                rd_addr1 = right_idx[ADDR_W-1:0];
            end
            OP_APPEND: begin
                wr_en   = !full;
                wr_addr = ADDR_W'(r_count);
                wr_data = r_value;
            end
            OP_SIFT_WRITE: begin
                wr_en   = 1'b1;
                wr_data = descend ? best_val : r_cur;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        r_rd0 <= r_mem[rd_addr0];
        r_rd1 <= r_mem[rd_addr1];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.op == OP_APPEND && !full) begin
                r_count <= r_count + CNT_W'(1);
            end else if (i_cmd.op == OP_EXT_TAKE) begin
                r_count <= r_count - CNT_W'(1);
            end
            if (i_cmd.op == OP_OUT_LOAD) begin
                r_out_valid <= 1'b1;
            end else if (i_rsp_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (i_cmd.op)
            OP_CAPTURE: begin
                r_kind  <= i_req_kind;
                r_value <= i_req_value;
                r_last  <= i_req_last;
            end
            OP_APPEND: begin
                r_res_value  <= VALUE_LOAD;
                r_res_status <= full ? STATUS_FULL : STATUS_OK;
            end
            OP_EXT_EMPTY: begin
                r_res_value  <= VALUE_EMPTY;
                r_res_status <= STATUS_EMPTY;
            end
            OP_EXT_TAKE: begin
                r_res_value  <= r_rd0;
                r_res_status <= STATUS_OK;
                r_cur        <= r_rd1;
                r_pos        <= '0;
            end
            OP_BLD_INIT: begin
                r_node <= r_count >> 1;
            end
            OP_BLD_DEC: begin
                r_node <= node_dec;
                r_pos  <= ADDR_W'(node_dec);
            end
            OP_CUR_TAKE: begin
                r_cur <= r_rd0;
            end
            OP_SIFT_WRITE: begin
                if (descend) begin
                    r_pos <= best_idx[ADDR_W-1:0];
                end
            end
            OP_OUT_LOAD: begin
                r_out_value  <= r_res_value;
                r_out_status <= r_res_status;
            end
            default: begin
            end
        endcase
    end

    assign o_stat.kind      = r_kind;
    assign o_stat.last      = r_last;
    assign o_stat.empty     = r_count == '0;
    assign o_stat.node_zero = r_node == '0;
    assign o_stat.sift_more = descend;
    assign o_stat.out_busy  = r_out_valid && !i_rsp_ready;

    assign o_rsp_valid  = r_out_valid;
    assign o_rsp_value  = r_out_value;
    assign o_rsp_status = r_out_status;

endmodule
`default_nettype wire

/* design/max_heap_priority_engine.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// max_heap_priority_engine
// Binary max-heap over signed 32-bit values with load, build and extract.
//
// Channel  Dir  tdata (low bit up)      tuser          tlast
// s_axis   in   value[31:0]             kind (1=ext)   last of load run
// m_axis   out  max_value[31:0]         status[1:0]    -
//
// One request at a time; the next is taken while a result waits in m_axis.
// Load: capture, append, output. Extract: capture, take root, sift per level.
// Load marked last adds the build: per internal node a take and a sift-down.
// Sift-down speed is set by the two-read, one-write heap store port.
// Reset clears the count; the store needs no clearing.
// ----------------------------------------------------------------------------
module max_heap_priority_engine
    import mhp_pkg::*;
#(
    parameter int unsigned HEAP_DEPTH = 1024
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                s_axis_tvalid,
    output logic                     s_axis_tready,
    input  wire logic [VALUE_W-1:0]  s_axis_tdata,  // value
    input  wire logic                s_axis_tuser,  // kind
    input  wire logic                s_axis_tlast,
    output logic                     m_axis_tvalid,
    input  wire logic                m_axis_tready,
    output logic [VALUE_W-1:0]       m_axis_tdata,  // max_value
    output logic [STATUS_W-1:0]      m_axis_tuser   // status
);

    t_dp_cmd  cmd;
    t_dp_stat stat;

    mhp_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (s_axis_tvalid),
        .o_req_ready (s_axis_tready),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    mhp_dpath #(
        .HEAP_DEPTH (HEAP_DEPTH)
    ) u_dpath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .i_req_kind   (s_axis_tuser),
        .i_req_value  (s_axis_tdata),
        .i_req_last   (s_axis_tlast),
        .i_rsp_ready  (m_axis_tready),
        .o_rsp_valid  (m_axis_tvalid),
        .o_rsp_value  (m_axis_tdata),
        .o_rsp_status (m_axis_tuser),
        .o_stat       (stat)
    );

endmodule
`default_nettype wire

/* test/heap_result_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// heap_result_checker
// Watches the request and result streams of the max-heap engine. It keeps its
// own copy of the heap store and element count and works out the result of
// every accepted request. Each accepted result is compared in order against
// the oldest outstanding prediction. It reports mismatches, the number of
// outstanding predictions and how many empty and full statuses were
// predicted.
// ----------------------------------------------------------------------------
module heap_result_checker
    import mhp_pkg::*;
#(
    parameter int unsigned HEAP_DEPTH = 1024
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_s_tvalid,
    input  wire logic                i_s_tready,
    input  wire logic [VALUE_W-1:0]  i_s_tdata,   // value[31:0]
    input  wire logic                i_s_tuser,   // kind
    input  wire logic                i_s_tlast,
    input  wire logic                i_m_tvalid,
    input  wire logic                i_m_tready,
    input  wire logic [VALUE_W-1:0]  i_m_tdata,   // max_value[31:0]
    input  wire logic [STATUS_W-1:0] i_m_tuser,   // status[1:0]
    output logic [31:0]              o_mismatch_count,
    output logic [31:0]              o_pending_count,
    output logic [31:0]              o_empty_count,
    output logic [31:0]              o_full_count
);

    typedef struct packed {
        logic signed [VALUE_W-1:0] max_value;
        logic [STATUS_W-1:0]       status;
    } t_heap_result;

    logic signed [VALUE_W-1:0] model_heap [HEAP_DEPTH];
    int unsigned               model_count;
    t_heap_result              awaited_results [$];
    t_heap_result              seen_result;
    t_heap_result              wanted_result;
    int unsigned               mismatch_total;
    int unsigned               empty_total;
    int unsigned               full_total;

    function automatic void sift_down_from(int unsigned start, int unsigned limit);
        int unsigned               pos;
        int unsigned               best;
        int unsigned               child;
        logic signed [VALUE_W-1:0] held;
        pos = start;
        while (pos < limit) begin
            best  = pos;
            child = 2 * pos + 1;
            // left child wins a tie; replace the parent only when strictly greater
            if (child < limit && model_heap[child] > model_heap[best]) best = child;
            if (child + 1 < limit && model_heap[child + 1] > model_heap[best]) best = child + 1;
            if (best == pos) break;
            held             = model_heap[pos];
            model_heap[pos]  = model_heap[best];
            model_heap[best] = held;
            pos              = best;
        end
    endfunction

    function automatic t_heap_result predict_heap_result(logic kind,
                                                         logic signed [VALUE_W-1:0] value,
                                                         logic last);
        t_heap_result res;
        int unsigned  node;
        res.max_value = VALUE_LOAD;
        res.status    = STATUS_OK;
        if (kind == KIND_LOAD) begin
            if (model_count >= HEAP_DEPTH) begin
                res.status = STATUS_FULL;
            end else begin
                model_heap[model_count] = value;
                model_count++;
            end
            if (last) begin
                for (node = model_count / 2; node > 0; node--)
                    sift_down_from(node - 1, model_count);
            end
        end else if (model_count == 0) begin
            res.max_value = VALUE_EMPTY;
            res.status    = STATUS_EMPTY;
        end else begin
            res.max_value = model_heap[0];
            model_count--;
            model_heap[0] = model_heap[model_count];
            sift_down_from(0, model_count);
        end
        return res;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            model_count = 0;
            awaited_results.delete();
            mismatch_total = 0;
            empty_total    = 0;
            full_total     = 0;
        end else begin
            if (i_m_tvalid && i_m_tready) begin
                seen_result.max_value = i_m_tdata;
                seen_result.status    = i_m_tuser;
                if (awaited_results.size() == 0) begin
                    mismatch_total++;
                    if (mismatch_total <= 10)
                        $display("mismatch: unexpected result max_value=%0d status=%0d",
                                 seen_result.max_value, seen_result.status);
                end else begin
                    wanted_result = awaited_results.pop_front();
                    if (wanted_result.status == STATUS_EMPTY) empty_total++;
                    if (wanted_result.status == STATUS_FULL) full_total++;
                    if (seen_result !== wanted_result) begin
                        mismatch_total++;
                        if (mismatch_total <= 10)
                            $display({"mismatch: expected max_value=%0d status=%0d,",
                                      " got max_value=%0d status=%0d"},
                                     wanted_result.max_value, wanted_result.status,
                                     seen_result.max_value, seen_result.status);
                    end
                end
            end
            if (i_s_tvalid && i_s_tready)
                awaited_results.push_back(predict_heap_result(i_s_tuser, i_s_tdata,
                                                              i_s_tlast));
        end
        o_mismatch_count <= mismatch_total;
        o_pending_count  <= awaited_results.size();
        o_empty_count    <= empty_total;
        o_full_count     <= full_total;
    end

endmodule

/* test/max_heap_priority_engine_test.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// max_heap_priority_engine_test
// Drives load and extract requests into the max-heap engine and randomly
// stalls its result stream. A directed part covers empty extracts, extreme
// and equal values, extracts before a build and loads after extracts. Random
// load runs with builds, broken runs and noise follow, and the run ends by
// overflowing the full store. A side checker predicts and compares results.
// ----------------------------------------------------------------------------
module max_heap_priority_engine_test;
    import mhp_pkg::*;

    localparam int unsigned HEAP_DEPTH       = 1024;
    localparam int unsigned RANDOM_REQUESTS  = 560;
    localparam int unsigned QUIET_TAIL       = 200;
    localparam int unsigned RUN_LIMIT_CYCLES = 20_000_000;

    logic                i_clk         = 1'b0;
    logic                i_rst_n       = 1'b0;
    logic                s_axis_tvalid = 1'b0;
    logic                s_axis_tready;
    logic [VALUE_W-1:0]  s_axis_tdata  = '0;   // value[31:0]
    logic                s_axis_tuser  = KIND_LOAD;  // kind
    logic                s_axis_tlast  = 1'b0;
    logic                m_axis_tvalid;
    logic                m_axis_tready = 1'b0;
    logic [VALUE_W-1:0]  m_axis_tdata;          // max_value[31:0]
    logic [STATUS_W-1:0] m_axis_tuser;          // status[1:0]

    logic [31:0] mismatch_count;
    logic [31:0] pending_count;
    logic [31:0] empty_count;
    logic [31:0] full_count;

    logic        idle_on = 1'b1;
    int          stall_left = 0;
    int unsigned requests_sent = 0;
    int unsigned loads_sent = 0;
    int unsigned extracts_sent = 0;
    int unsigned builds_sent = 0;
    int unsigned occupancy = 0;
    int unsigned random_goal;
    int unsigned shape;
    int unsigned run_size;

    max_heap_priority_engine #(
        .HEAP_DEPTH(HEAP_DEPTH)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    heap_result_checker #(
        .HEAP_DEPTH(HEAP_DEPTH)
    ) result_checker (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_s_tvalid       (s_axis_tvalid),
        .i_s_tready       (s_axis_tready),
        .i_s_tdata        (s_axis_tdata),
        .i_s_tuser        (s_axis_tuser),
        .i_s_tlast        (s_axis_tlast),
        .i_m_tvalid       (m_axis_tvalid),
        .i_m_tready       (m_axis_tready),
        .i_m_tdata        (m_axis_tdata),
        .i_m_tuser        (m_axis_tuser),
        .o_mismatch_count (mismatch_count),
        .o_pending_count  (pending_count),
        .o_empty_count    (empty_count),
        .o_full_count     (full_count)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        if (stall_left == 0 && idle_on && $urandom_range(0, 9) == 0)
            stall_left = $urandom_range(1, 12);
        if (stall_left > 0) begin
            m_axis_tready <= 1'b0;
            stall_left--;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    function automatic logic [VALUE_W-1:0] pick_value();
        logic [VALUE_W-1:0] v;
        case ($urandom_range(0, 9))
            6, 7:    v = $urandom_range(0, 6) - 3;
            8:       v = $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
            9:       v = $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h0000_0000;
            default: v = $urandom;
        endcase
        return v;
    endfunction

    task automatic send_request(input logic kind, input logic [VALUE_W-1:0] value,
                                input logic last);
        if (idle_on && $urandom_range(0, 5) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= value;
        s_axis_tuser  <= kind;
        s_axis_tlast  <= last;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        requests_sent++;
        if (kind == KIND_LOAD) begin
            loads_sent++;
            if (last) builds_sent++;
            if (occupancy < HEAP_DEPTH) occupancy++;
        end else begin
            extracts_sent++;
            if (occupancy > 0) occupancy--;
        end
    endtask

    task automatic load_run(input int unsigned count, input logic mark_last);
        for (int unsigned i = 0; i < count; i++)
            send_request(KIND_LOAD, pick_value(), mark_last && (i == count - 1));
    endtask

    task automatic extract_run(input int unsigned count);
        repeat (count) send_request(KIND_EXTRACT, $urandom, 1'($urandom_range(0, 1)));
    endtask

    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending_count != 0) @(posedge i_clk);
    endtask

    initial begin
        #(RUN_LIMIT_CYCLES * 10);
        $display("max_heap_priority_engine regression: fail");
        $finish;
    end

    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        repeat (2) @(posedge i_clk);

        send_request(KIND_EXTRACT, $urandom, 1'b0);
        send_request(KIND_LOAD, 32'h7FFF_FFFF, 1'b0);
        send_request(KIND_LOAD, 32'h8000_0000, 1'b0);
        send_request(KIND_LOAD, 32'h0000_0000, 1'b0);
        send_request(KIND_LOAD, 32'hFFFF_FFFF, 1'b0);
        send_request(KIND_LOAD, 32'd5, 1'b0);
        send_request(KIND_LOAD, 32'd5, 1'b1);
        extract_run(7);
        // extract from an unbuilt store, then append after extracts and rebuild
        send_request(KIND_LOAD, 32'd1, 1'b0);
        send_request(KIND_LOAD, 32'd9, 1'b0);
        send_request(KIND_LOAD, 32'd4, 1'b0);
        extract_run(1);
        send_request(KIND_LOAD, 32'd2, 1'b0);
        send_request(KIND_LOAD, 32'd7, 1'b1);
        extract_run(4);
        send_request(KIND_EXTRACT, $urandom, 1'b1);
        wait_drained();

        random_goal = requests_sent + RANDOM_REQUESTS;
        while (requests_sent < random_goal) begin
            if (requests_sent + QUIET_TAIL >= random_goal)
                idle_on <= 1'b0;
            else
                idle_on <= ($urandom_range(0, 3) != 0);
            shape = $urandom_range(0, 19);
            if (shape < 14) begin
                run_size = ($urandom_range(0, 15) == 0) ? $urandom_range(25, 120)
                                                       : $urandom_range(1, 24);
                load_run(run_size, 1'b1);
                if ($urandom_range(0, 1))
                    extract_run(occupancy + $urandom_range(0, 2));
                else
                    extract_run($urandom_range(0, run_size));
            end else if (shape < 17) begin
                load_run($urandom_range(1, 8), 1'b0);
                extract_run($urandom_range(1, 4));
            end else begin
                repeat ($urandom_range(1, 10))
                    send_request(1'($urandom_range(0, 1)), pick_value(),
                                 1'($urandom_range(0, 1)));
            end
            if ($urandom_range(0, 9) == 0) wait_drained();
        end

        // fill the store, overflow it and build on the dropped final load
        idle_on <= 1'b0;
        wait_drained();
        load_run(HEAP_DEPTH - occupancy + 3, 1'b1);
        extract_run(24);

        wait_drained();
        repeat (100) @(posedge i_clk);

        $display("Ran %0d requests: %0d loads, %0d extracts, %0d heap builds.",
                 requests_sent, loads_sent, extracts_sent, builds_sent);
        $display("Hit %0d empty extracts and %0d loads dropped on a full store; %0d mismatches.",
                 empty_count, full_count, mismatch_count);
        if (mismatch_count == 0 && pending_count == 0) begin
            $display("max_heap_priority_engine regression: pass");
        end else begin
            $display("max_heap_priority_engine regression: fail");
        end
        $finish;
    end

endmodule
